// ===== design/ac_presence_majority_detector_defines.svh =====
// ----------------------------------------------------------------------------
// AC presence detector assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef AC_PRESENCE_MAJORITY_DETECTOR_DEFINES_SVH
`define AC_PRESENCE_MAJORITY_DETECTOR_DEFINES_SVH

// Same-cycle implication
`define AC_PMD_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication
`define AC_PMD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== design/ac_pmd_pkg.sv =====
// ----------------------------------------------------------------------------
// AC presence detector package
// Shared types, constants and register map for the majority-vote detector.
// ----------------------------------------------------------------------------
package ac_pmd_pkg;

  // Vote ring depth and derived widths
  localparam int VOTE_DEPTH = 10;
  localparam int RING_IDX_W = (VOTE_DEPTH > 1) ? $clog2(VOTE_DEPTH) : 1;
  localparam int COUNT_W    = $clog2(VOTE_DEPTH + 1);

  // Field widths
  localparam int TIME_W   = 32;
  localparam int LIMIT_W  = 24;
  localparam int THRESH_W = 6;

  // APB port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // Register reset values
  localparam logic [LIMIT_W-1:0]  PERIOD_MIN_RST = LIMIT_W'(8000);
  localparam logic [LIMIT_W-1:0]  PERIOD_MAX_RST = LIMIT_W'(25000);
  localparam logic [LIMIT_W-1:0]  EDGE_GAP_RST   = LIMIT_W'(50000);
  localparam logic [LIMIT_W-1:0]  VALID_GAP_RST  = LIMIT_W'(500000);
  localparam logic [THRESH_W-1:0] THRESHOLD_RST  = THRESH_W'(7);

  // Register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_PERIOD_MIN = 3'd0,
    REG_PERIOD_MAX = 3'd1,
    REG_EDGE_GAP   = 3'd2,
    REG_VALID_GAP  = 3'd3,
    REG_THRESHOLD  = 3'd4
  } reg_idx_t;

  // Configuration as seen by the core
  typedef struct packed {
    logic [LIMIT_W-1:0]  period_min_us;
    logic [LIMIT_W-1:0]  period_max_us;
    logic [LIMIT_W-1:0]  edge_gap_limit_us;
    logic [LIMIT_W-1:0]  valid_gap_limit_us;
    logic [THRESH_W-1:0] vote_threshold;
  } cfg_t;

  // Input transaction
  typedef struct packed {
    logic              level;
    logic [TIME_W-1:0] time_now_us;
  } sample_t;

  // Result transaction
  typedef struct packed {
    logic                ac_present;
    logic [THRESH_W-1:0] vote_count;
  } status_t;

endpackage

// ===== design/ac_pmd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// AC presence detector configuration registers
// APB register bank holding the period window, gap limits and vote threshold.
// ----------------------------------------------------------------------------
module ac_pmd_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ac_pmd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ac_pmd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ac_pmd_pkg::APB_DATA_W-1:0] prdata,
  output logic                              pready,
  output ac_pmd_pkg::cfg_t                  cfg
);
  import ac_pmd_pkg::*;

  logic     wr_en;
  reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[4:2]);

  // Register writes; unmapped indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_min_us      <= PERIOD_MIN_RST;
      cfg.period_max_us      <= PERIOD_MAX_RST;
      cfg.edge_gap_limit_us  <= EDGE_GAP_RST;
      cfg.valid_gap_limit_us <= VALID_GAP_RST;
      cfg.vote_threshold     <= THRESHOLD_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PERIOD_MIN: cfg.period_min_us      <= pwdata[LIMIT_W-1:0];
        REG_PERIOD_MAX: cfg.period_max_us      <= pwdata[LIMIT_W-1:0];
        REG_EDGE_GAP:   cfg.edge_gap_limit_us  <= pwdata[LIMIT_W-1:0];
        REG_VALID_GAP:  cfg.valid_gap_limit_us <= pwdata[LIMIT_W-1:0];
        REG_THRESHOLD:  cfg.vote_threshold     <= pwdata[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    unique case (reg_idx)
      REG_PERIOD_MIN: prdata = APB_DATA_W'(cfg.period_min_us);
      REG_PERIOD_MAX: prdata = APB_DATA_W'(cfg.period_max_us);
      REG_EDGE_GAP:   prdata = APB_DATA_W'(cfg.edge_gap_limit_us);
      REG_VALID_GAP:  prdata = APB_DATA_W'(cfg.valid_gap_limit_us);
      REG_THRESHOLD:  prdata = APB_DATA_W'(cfg.vote_threshold);
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== design/ac_pmd_vote_core.sv =====
// ----------------------------------------------------------------------------
// AC presence detector vote core
// Edge timing, vote ring with running count, and the presence decision.
// ----------------------------------------------------------------------------
module ac_pmd_vote_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  ac_pmd_pkg::sample_t   sample,
  input  ac_pmd_pkg::cfg_t      cfg,
  output ac_pmd_pkg::status_t   result
);
  import ac_pmd_pkg::*;

  // Detector state
  logic                  prev_level;
  logic [TIME_W-1:0]     last_edge_time;
  logic [TIME_W-1:0]     last_good_edge_time;
  logic [VOTE_DEPTH-1:0] vote_ring;
  logic [RING_IDX_W-1:0] ring_pos;
  logic [COUNT_W-1:0]    ones_count;

  logic [TIME_W-1:0]     last_good_edge_time_next;
  logic [RING_IDX_W-1:0] ring_pos_next;
  logic [COUNT_W-1:0]    ones_count_next;

  logic              rise;
  logic [TIME_W-1:0] edge_dt;
  logic [TIME_W-1:0] good_dt;
  logic              in_window;
  logic              push;
  logic              vote;
  logic              old_vote;
  logic              votes_ok;

  // Edge detection and period check (differences wrap mod 2^32)
  always_comb begin
    rise      = sample.level && !prev_level;
    edge_dt   = sample.time_now_us - last_edge_time;
    in_window = (edge_dt >= TIME_W'(cfg.period_min_us)) &&
                (edge_dt <= TIME_W'(cfg.period_max_us));
    vote      = rise && in_window;
    push      = rise || (edge_dt > TIME_W'(cfg.edge_gap_limit_us));
  end

  // Ring slot update and running count
  always_comb begin
    old_vote        = vote_ring[ring_pos];
    ones_count_next = ones_count;
    ring_pos_next   = ring_pos;
    if (push) begin
      ones_count_next = ones_count - COUNT_W'(old_vote) + COUNT_W'(vote);
      ring_pos_next   = (ring_pos == RING_IDX_W'(VOTE_DEPTH - 1)) ? '0
                                                                  : ring_pos + 1'b1;
    end
  end

  // Presence decision on the updated state
  always_comb begin
    last_good_edge_time_next = vote ? sample.time_now_us : last_good_edge_time;
    good_dt   = sample.time_now_us - last_good_edge_time_next;
    votes_ok  = THRESH_W'(ones_count_next) >= cfg.vote_threshold;
    result.ac_present = votes_ok && (good_dt <= TIME_W'(cfg.valid_gap_limit_us));
    result.vote_count = THRESH_W'(ones_count_next);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level          <= 1'b0;
      last_edge_time      <= '0;
      last_good_edge_time <= '0;
      vote_ring           <= '0;
      ring_pos            <= '0;
      ones_count          <= '0;
    end else if (step) begin
      prev_level          <= sample.level;
      last_good_edge_time <= last_good_edge_time_next;
      ring_pos            <= ring_pos_next;
      ones_count          <= ones_count_next;
      if (rise) begin
        last_edge_time <= sample.time_now_us;
      end
      if (push) begin
        vote_ring[ring_pos] <= vote;
      end
    end
  end

endmodule

// ===== design/ac_presence_majority_detector.sv =====
// ----------------------------------------------------------------------------
// AC presence majority detector
// Votes on rising-edge periods of a zero-crossing input and reports presence.
//
//   channel  direction  handshake            payload
//   sample   in         sample_valid/stall   level, time_now_us
//   status   out        status_valid/stall   ac_present, vote_count
//   apb      in/out     psel/penable/pready  5 registers at 4-byte spacing
//
// One transaction per cycle while status is not stalled; an accepted sample
// passes the input register, then the result register fed by the vote core.
// Reset (rst, synchronous) clears the pipeline, the vote state and loads
// the register defaults. A stall on status holds the result register and
// backs up through the input register to sample_stall in the same cycle.
// ----------------------------------------------------------------------------
module ac_presence_majority_detector (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  ac_pmd_pkg::sample_t               sample,
  output logic                              status_valid,
  input  logic                              status_stall,
  output ac_pmd_pkg::status_t               status,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ac_pmd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ac_pmd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ac_pmd_pkg::APB_DATA_W-1:0] prdata,
  output logic                              pready
);
  import ac_pmd_pkg::*;

  `include "ac_presence_majority_detector_defines.svh"

  cfg_t    cfg;
  sample_t in_reg;
  logic    in_reg_valid;
  status_t core_result;
  logic    out_free;
  logic    step;
  logic    take;

  // Pipeline control
  assign out_free     = !status_valid || !status_stall;
  assign step         = in_reg_valid && out_free;
  assign sample_stall = in_reg_valid && !out_free;
  assign take         = sample_valid && !sample_stall;

  ac_pmd_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ac_pmd_vote_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .sample (in_reg),
    .cfg    (cfg),
    .result (core_result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!sample_stall) begin
      in_reg_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_reg <= sample;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
    end else if (out_free) begin
      status_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      status <= core_result;
    end
  end

  // Checks
  `AC_PMD_ASSERT_NOW(a_count_in_range, status_valid, status.vote_count <= THRESH_W'(VOTE_DEPTH), "vote count exceeds ring depth")
  `AC_PMD_ASSERT_NOW(a_present_needs_votes, status_valid && status.ac_present, status.vote_count >= cfg.vote_threshold, "presence reported below threshold")
  `AC_PMD_ASSERT_NOW(a_stall_only_when_full, sample_stall, in_reg_valid && status_valid && status_stall, "input stalled with room downstream")
  `AC_PMD_ASSERT_NEXT(a_held_item_kept, in_reg_valid && !out_free, in_reg_valid && $stable(in_reg), "held input register lost its item")

endmodule
